### rtl/fgmcq_pkg.sv
`timescale 1ns / 1ps
package fgmcq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IO_W      = FRAC_BITS + 1;
    localparam int TH_W      = 16;
    localparam int A_W       = TH_W + IO_W + 1;
    localparam int AMAG_W    = 30;
    localparam int MW_W      = 32;
    localparam int P_W       = AMAG_W + MW_W;
    localparam int RS_SH     = 2 * FRAC_BITS + 14;
    localparam int CMP_W     = 64;

    localparam logic [IO_W-1:0]        ONE       = IO_W'(1) << FRAC_BITS;
    localparam logic signed [TH_W-1:0] THETA_MAX = 16'sd16384;
    localparam logic [TH_W-1:0]        THETA_RST = 16'd8192;

    // front: capture, alpha product, magnitude; then three stages per result bit
    localparam int NFRONT = 3;
    localparam int NSTG   = NFRONT + 3 * IO_W;

    typedef struct packed {
        logic [IO_W-1:0]          q;
        logic [IO_W-1:0]          u;
        logic signed [TH_W-1:0]   th;
        logic signed [A_W-1:0]    a;
        logic                     a_neg;
        logic [AMAG_W-1:0]        a_mag;
        logic [IO_W-1:0]          res;
        logic [IO_W-1:0]          cand;
        logic [IO_W-1:0]          m;
        logic                     cand_ok;
        logic [MW_W-1:0]          mw;
        logic [P_W-1:0]           p;
    } t_stg;

endpackage

### rtl/fgmcq_if.sv
`timescale 1ns / 1ps
interface fgmcq_in_if
    import fgmcq_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [IO_W-1:0] cond_u;
    logic [IO_W-1:0] level_q;

    modport source (output valid, output cond_u, output level_q, input ready);
    modport sink   (input valid, input cond_u, input level_q, output ready);
endinterface

interface fgmcq_out_if
    import fgmcq_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [IO_W-1:0] sample_v;

    modport source (output valid, output sample_v, input ready);
    modport sink   (input valid, input sample_v, output ready);
endinterface

### rtl/fgm_copula_conditional_quantile.sv
`timescale 1ns / 1ps
// FGM copula conditional quantile: for each request (cond_u, level_q) returns
// sample_v, the root of v*(1+alpha) - alpha*v^2 = q with alpha = theta*(1-2u),
// rounded to nearest and held to 0..1.0. Inputs above 1.0 and theta outside
// -1.0..1.0 are saturated. One request is taken every cycle unless the output
// stalls. Three front stages form alpha, then a restoring search decides one
// result bit per three stages (m*(1-m) product, alpha product, compare), 17
// bits in all. The whole pipeline holds while a result waits at the output.
// The user must write theta only while no request is in flight; not enforced.
module fgm_copula_conditional_quantile
    import fgmcq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TH_W-1:0]   i_cfg_wdata,
    fgmcq_in_if.sink          i_in,
    fgmcq_out_if.source       o_out
);

    logic [TH_W-1:0] r_theta;
    logic            adv;
    logic            r_vld [NSTG];
    t_stg            r_st  [NSTG];
    t_stg            n_st  [NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= THETA_RST;
        end else if (i_cfg_we) begin
            r_theta <= i_cfg_wdata;
        end
    end

    assign adv         = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_vld[NSTG-1];
    assign o_out.sample_v = r_st[NSTG-1].res;

    // stage 0: saturate inputs
    always_comb begin
        logic signed [TH_W-1:0] th;
        th = signed'(r_theta);
        n_st[0]   = '0;
        n_st[0].u = (i_in.cond_u > ONE) ? ONE : i_in.cond_u;
        n_st[0].q = (i_in.level_q > ONE) ? ONE : i_in.level_q;
        if (th > THETA_MAX) begin
            n_st[0].th = THETA_MAX;
        end else if (th < -THETA_MAX) begin
            n_st[0].th = -THETA_MAX;
        end else begin
            n_st[0].th = th;
        end
    end

    // stage 1: alpha scaled = th * (half - u)
    always_comb begin
        logic signed [IO_W:0]  d;
        logic signed [A_W-1:0] th_x;
        logic signed [A_W-1:0] d_x;
        d    = signed'({1'b0, ONE >> 1}) - signed'({1'b0, r_st[0].u});
        th_x = A_W'(r_st[0].th);
        d_x  = A_W'(d);
        n_st[1]   = r_st[0];
        n_st[1].a = th_x * d_x;
    end

    // stage 2: magnitude
    always_comb begin
        logic signed [A_W-1:0] na;
        na = -r_st[1].a;
        n_st[2]       = r_st[1];
        n_st[2].a_neg = r_st[1].a[A_W-1];
        n_st[2].a_mag = r_st[1].a[A_W-1] ? AMAG_W'(na) : AMAG_W'(r_st[1].a);
        n_st[2].res   = '0;
    end

    for (genvar s = NFRONT; s < NSTG; s++) begin : g_srch
        localparam int STEP = (s - NFRONT) / 3;
        localparam int PH   = (s - NFRONT) % 3;
        localparam int BIT  = IO_W - 1 - STEP;

        if (PH == 0) begin : g_mw
            always_comb begin
                logic [IO_W-1:0] cand;
                logic [IO_W-1:0] m;
                logic [IO_W:0]   rest;
                cand = r_st[s-1].res | (IO_W'(1) << BIT);
                m    = IO_W'({cand, 1'b0} - (IO_W+1)'(1));
                rest = (IO_W+1)'(1) << IO_W;
                rest = rest - {1'b0, m};
                n_st[s]         = r_st[s-1];
                n_st[s].cand    = cand;
                n_st[s].m       = m;
                n_st[s].cand_ok = (cand <= ONE);
                n_st[s].mw      = MW_W'(m) * MW_W'(rest[IO_W-1:0]);
            end
        end else if (PH == 1) begin : g_prod
            always_comb begin
                n_st[s]   = r_st[s-1];
                n_st[s].p = P_W'(r_st[s-1].a_mag) * P_W'(r_st[s-1].mw);
            end
        end else begin : g_cmp
            always_comb begin
                logic signed [IO_W+1:0] r;
                logic [IO_W+1:0]        rmag;
                logic [CMP_W-1:0]       rs;
                logic [CMP_W-1:0]       pw;
                logic                   r_pos;
                logic                   below;
                r     = signed'({1'b0, r_st[s-1].q, 1'b0}) - signed'({2'b0, r_st[s-1].m});
                r_pos = !r[IO_W+1];
                rmag  = r_pos ? unsigned'(r) : unsigned'(-r);
                rs    = CMP_W'(rmag) << RS_SH;
                pw    = CMP_W'(r_st[s-1].p);
                if (!r_st[s-1].a_neg) begin
                    below = r_pos && (pw <= rs);
                end else begin
                    below = r_pos || (rs <= pw);
                end
                n_st[s] = r_st[s-1];
                if (r_st[s-1].cand_ok && below) begin
                    n_st[s].res = r_st[s-1].cand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NSTG; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule
